FILE: src/ces_pkg.sv
`default_nettype none

package ces_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned MVOL_W  = 4;

  localparam logic [BYTE_W-1:0]  LEVEL_MAX    = 8'hFF;
  localparam logic [BYTE_W:0]    ATTACK_LIMIT = 9'h0FE;
  localparam logic [MVOL_W-1:0]  MVOL_RESET   = 4'hF;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_VOLUME  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ENV_NONE    = 2'd0,
    ENV_ATTACK  = 2'd1,
    ENV_DECAY   = 2'd2,
    ENV_SUSTAIN = 2'd3
  } env_e;

  localparam logic [PHASE_W-1:0] PH_OFF     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_ECHO    = 3'd5;

  // Per-channel status word, 14 bits.
  typedef struct packed {
    env_e              env;
    logic              echo;
    logic              stop;
    logic              start;
    logic              active;
    logic [BYTE_W-1:0] level;
  } status_t;

  // Per-channel settings word, 64 bits.
  typedef struct packed {
    logic [BYTE_W-1:0] vol_r;
    logic [BYTE_W-1:0] vol_l;
    logic [BYTE_W-1:0] echo_cnt;
    logic [BYTE_W-1:0] echo_lvl;
    logic [BYTE_W-1:0] rel_factor;
    logic [BYTE_W-1:0] sustain;
    logic [BYTE_W-1:0] decay;
    logic [BYTE_W-1:0] attack;
  } settings_t;

  localparam int unsigned STATUS_W   = $bits(status_t);
  localparam int unsigned SETTINGS_W = $bits(settings_t);

endpackage

`default_nettype wire

FILE: src/ces_ram.sv
`default_nettype none

module ces_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/channel_envelope_step_top.sv
// Envelope step engine for a bank of CHANNELS sound channels.
//
// Input channel (in_valid_i / in_ready_o): one beat carries a command and a
// channel index plus note settings. Tick advances the channel envelope one
// step (attack, decay, sustain, release, echo tail); start latches settings
// and arms the note; release requests the release phase; set volumes
// replaces the left and right volumes. Every beat yields one result beat.
// Output channel (out_valid_o / out_ready_i): the channel's state after the
// beat and its level scaled by master volume and by left/right volume.
// Config channel (cfg_valid_i / cfg_ready_o): writes the 4-bit master volume;
// always ready, write it only while the block is idle.
// A new beat is taken only once the previous result has entered the output
// register. Status and settings live in two registered-read RAMs; the
// sequencer reads, modifies and writes back, then uses a single 8x8
// multiplier three more times for the output scaling.
// A held result does not block input; only the final stage waits for the
// output register to free up when the receiver stalls.
// Reset: all channels off (per-channel valid bits mask the status RAM,
// no clearing pass), master volume 15, no result pending.
`default_nettype none

module channel_envelope_step_top #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ces_pkg::MVOL_W-1:0]    master_volume_i,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ces_pkg::CMD_W-1:0]     command_i,
  input  wire logic [ces_pkg::CHAN_W-1:0]    channel_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    attack_rate_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    decay_factor_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    sustain_level_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    release_factor_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    echo_level_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    echo_ticks_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    volume_left_i,
  input  wire logic [ces_pkg::BYTE_W-1:0]    volume_right_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [ces_pkg::CHAN_W-1:0]    channel_out_o,
  output logic                               active_o,
  output logic      [ces_pkg::PHASE_W-1:0]   phase_o,
  output logic      [ces_pkg::BYTE_W-1:0]    envelope_level_o,
  output logic      [ces_pkg::BYTE_W-1:0]    level_left_o,
  output logic      [ces_pkg::BYTE_W-1:0]    level_right_o
);

  import ces_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Sequencer: read status/settings, modify and write back, then scale.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_SCALE = 5'b00100,
    S_LEFT  = 5'b01000,
    S_RIGHT = 5'b10000
  } seq_e;

  seq_e state_q, state_d;

  logic [MVOL_W-1:0]   master_q;
  logic [CHANNELS-1:0] st_valid_q;
  logic                rd_valid_q;
  logic                out_valid_q;

  // Item payload held across the sequence
  cmd_e              cmd_q;
  logic [CHAN_W-1:0] chan_q;
  logic [AW-1:0]     addr_q;
  logic              in_range_q;
  settings_t         item_set_q;

  // Results of the read-modify-write and of the scaling passes
  status_t           stat_q;
  settings_t         set_q;
  logic [BYTE_W-1:0] scaled_q;
  logic [BYTE_W-1:0] left_q;

  logic [CHAN_W-1:0]  out_chan_q;
  logic               out_active_q;
  logic [PHASE_W-1:0] out_phase_q;
  logic [BYTE_W-1:0]  out_level_q;
  logic [BYTE_W-1:0]  out_left_q;
  logic [BYTE_W-1:0]  out_right_q;

  logic [AW+CHAN_W-1:0] chan_ext;
  logic [AW-1:0]        chan_addr;
  logic                 chan_in_range;
  logic                 in_fire;
  logic                 out_load;

  logic [STATUS_W-1:0]   st_rdata;
  logic [SETTINGS_W-1:0] cs_rdata;
  logic                  mem_we;

  status_t   st_rd, st_new;
  settings_t cs_rd, cs_new;

  logic [BYTE_W-1:0]   mul_a, mul_b;
  logic [2*BYTE_W-1:0] mul_p;
  logic [BYTE_W-1:0]   mlevel;
  logic [BYTE_W:0]     asum;
  logic [PHASE_W-1:0]  phase_now;

  // Channel index to RAM address; high channels beyond CHANNELS are dropped
  assign chan_ext      = {{AW{1'b0}}, channel_i};
  assign chan_addr     = chan_ext[AW-1:0];
  assign chan_in_range = (32'(channel_i) < CHANNELS);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_RIGHT) && (!out_valid_q || out_ready_i);
  assign mem_we      = (state_q == S_EVAL) && in_range_q;

  ces_ram #(
    .WIDTH (STATUS_W),
    .DEPTH (CHANNELS)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (STATUS_W'(st_new)),
    .raddr_i (chan_addr),
    .rdata_o (st_rdata)
  );

  ces_ram #(
    .WIDTH (SETTINGS_W),
    .DEPTH (CHANNELS)
  ) u_settings_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (SETTINGS_W'(cs_new)),
    .raddr_i (chan_addr),
    .rdata_o (cs_rdata)
  );

  // An entry never written since reset reads as an off channel
  assign st_rd = rd_valid_q ? status_t'(st_rdata) : '0;
  assign cs_rd = settings_t'(cs_rdata);

  // Shared 8x8 multiplier, operands picked by the sequencer step
  always_comb begin
    unique case (state_q)
      S_EVAL: begin
        mul_a = st_rd.level;
        mul_b = st_rd.stop ? cs_rd.rel_factor : cs_rd.decay;
      end
      S_SCALE: begin
        mul_a = stat_q.level;
        mul_b = {{(BYTE_W-MVOL_W){1'b0}}, master_q} + BYTE_W'(1);
      end
      S_LEFT: begin
        mul_a = scaled_q;
        mul_b = set_q.vol_l;
      end
      S_RIGHT: begin
        mul_a = scaled_q;
        mul_b = set_q.vol_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign mlevel = mul_p[2*BYTE_W-1:BYTE_W];
  assign asum   = {1'b0, st_rd.level} + {1'b0, cs_rd.attack};

  // Modify step: apply the command to the status and settings just read
  always_comb begin
    st_new = st_rd;
    cs_new = cs_rd;
    unique case (cmd_q)
      CMD_TICK: begin
        priority if (!st_rd.active) begin
          st_new = '0;
        end else if (st_rd.start) begin
          st_new = '0;
          if (!st_rd.stop) begin
            st_new.active = 1'b1;
            st_new.level  = cs_rd.attack;
            st_new.env    = (cs_rd.attack == LEVEL_MAX) ? ENV_DECAY : ENV_ATTACK;
          end
        end else if (st_rd.echo) begin
          // Hold the level and count the tail down
          if (cs_rd.echo_cnt == '0) begin
            st_new = '0;
          end else begin
            cs_new.echo_cnt = cs_rd.echo_cnt - BYTE_W'(1);
          end
        end else if (st_rd.stop) begin
          if (mlevel <= cs_rd.echo_lvl) begin
            if (cs_rd.echo_lvl == '0) begin
              st_new = '0;
            end else begin
              st_new.echo  = 1'b1;
              st_new.level = cs_rd.echo_lvl;
            end
          end else begin
            st_new.level = mlevel;
          end
        end else if (st_rd.env == ENV_ATTACK) begin
          if (asum > ATTACK_LIMIT) begin
            st_new.env   = ENV_DECAY;
            st_new.level = LEVEL_MAX;
          end else begin
            st_new.level = asum[BYTE_W-1:0];
          end
        end else if (st_rd.env == ENV_DECAY) begin
          if (mlevel <= cs_rd.sustain) begin
            if ((cs_rd.sustain == '0) && (cs_rd.echo_lvl == '0)) begin
              st_new = '0;
            end else begin
              st_new.env   = ENV_SUSTAIN;
              st_new.level = cs_rd.sustain;
            end
          end else begin
            st_new.level = mlevel;
          end
        end else begin
          st_new = st_rd;
        end
      end
      CMD_START: begin
        cs_new        = item_set_q;
        st_new        = '0;
        st_new.active = 1'b1;
        st_new.start  = 1'b1;
        st_new.env    = (item_set_q.attack == LEVEL_MAX) ? ENV_DECAY : ENV_ATTACK;
      end
      CMD_RELEASE: begin
        if (st_rd.active) begin
          st_new.stop = 1'b1;
        end
      end
      CMD_VOLUME: begin
        cs_new.vol_l = item_set_q.vol_l;
        cs_new.vol_r = item_set_q.vol_r;
      end
      default: begin
        st_new = st_rd;
      end
    endcase
  end

  always_comb begin
    priority if (stat_q.echo) begin
      phase_now = PH_ECHO;
    end else if (stat_q.stop) begin
      phase_now = PH_RELEASE;
    end else begin
      phase_now = {1'b0, stat_q.env};
    end
  end

  // Advance one step per cycle; hold the last step while the output is full
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EVAL;
      S_EVAL:  state_d = S_SCALE;
      S_SCALE: state_d = S_LEFT;
      S_LEFT:  state_d = S_RIGHT;
      S_RIGHT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      master_q    <= MVOL_RESET;
      st_valid_q  <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        master_q <= master_volume_i;
      end
      if (mem_we) begin
        st_valid_q[addr_q] <= 1'b1;
      end
      if (in_fire) begin
        rd_valid_q <= chan_in_range ? st_valid_q[chan_addr] : 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q                 <= cmd_e'(command_i);
      chan_q                <= channel_i;
      addr_q                <= chan_addr;
      in_range_q            <= chan_in_range;
      item_set_q.attack     <= attack_rate_i;
      item_set_q.decay      <= decay_factor_i;
      item_set_q.sustain    <= sustain_level_i;
      item_set_q.rel_factor <= release_factor_i;
      item_set_q.echo_lvl   <= echo_level_i;
      item_set_q.echo_cnt   <= echo_ticks_i;
      item_set_q.vol_l      <= volume_left_i;
      item_set_q.vol_r      <= volume_right_i;
    end
    if (state_q == S_EVAL) begin
      stat_q <= st_new;
      set_q  <= cs_new;
    end
    if (state_q == S_SCALE) begin
      scaled_q <= mul_p[BYTE_W+MVOL_W-1:MVOL_W];
    end
    if (state_q == S_LEFT) begin
      left_q <= mlevel;
    end
    if (out_load) begin
      out_chan_q <= chan_q;
      if (in_range_q && stat_q.active) begin
        out_active_q <= 1'b1;
        out_phase_q  <= phase_now;
        out_level_q  <= stat_q.level;
        out_left_q   <= left_q;
        out_right_q  <= mlevel;
      end else begin
        out_active_q <= 1'b0;
        out_phase_q  <= PH_OFF;
        out_level_q  <= '0;
        out_left_q   <= '0;
        out_right_q  <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_out_o    = out_chan_q;
  assign active_o         = out_active_q;
  assign phase_o          = out_phase_q;
  assign envelope_level_o = out_level_q;
  assign level_left_o     = out_left_q;
  assign level_right_o    = out_right_q;

  // A taken beat runs the read-modify-write, the master-volume scaling and the left scaling in order
  a_seq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_EVAL) ##1 (state_q == S_SCALE) ##1 (state_q == S_LEFT))
    else $error("sequencer skipped a step");

  // A sounding channel always reports a real phase
  a_active_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_o |-> (phase_o != PH_OFF))
    else $error("active result with phase off");

  // A silent channel reports all zero
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |->
      (phase_o == PH_OFF) && (envelope_level_o == '0) &&
      (level_left_o == '0) && (level_right_o == '0))
    else $error("inactive result carries nonzero fields");

  // During the echo tail the stored level is the echo level
  a_echo_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RIGHT) && in_range_q && stat_q.active && stat_q.echo |->
      (stat_q.level == set_q.echo_lvl))
    else $error("echo level not held");

endmodule

`default_nettype wire
